[src/tbls_pkg.sv]
`default_nettype none

package tbls_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // widths fixed by the item fields
    localparam int ACT_W = 2;
    localparam int POS_W = 10;
    localparam int KEY_W = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_BSEARCH = 2'd1,
        ACT_LSEARCH = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } state_t;

    // search bounds: low runs up to the depth, high down to minus one
    typedef logic signed [IDX_W+1:0] bound_t;

    typedef struct packed {
        logic             hit;
        logic             empty;
        bound_t           lo_next;
        bound_t           hi_next;
        logic [IDX_W-1:0] addr_next;
    } probe_t;

    function automatic logic [IDX_W-1:0] probe_addr(action_t mode, bound_t lo, bound_t hi);
        bound_t mid;
        if (mode == ACT_BSEARCH)
            mid = lo + ((hi - lo) >>> 1);
        else
            mid = lo;
        return mid[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/tbls_req_if.sv]
`default_nettype none

interface tbls_req_if;
    logic                       valid;
    logic                       ready;
    logic [tbls_pkg::ACT_W-1:0] action;
    logic [tbls_pkg::POS_W-1:0] entry_index;
    logic signed [tbls_pkg::KEY_W-1:0] entry_value;
    logic [tbls_pkg::POS_W-1:0] range_low;
    logic [tbls_pkg::POS_W-1:0] range_high;
    logic signed [tbls_pkg::KEY_W-1:0] search_key;

    modport source (
        output valid, action, entry_index, entry_value, range_low, range_high, search_key,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_value, range_low, range_high, search_key,
        output ready
    );
endinterface

`default_nettype wire

[src/tbls_rsp_if.sv]
`default_nettype none

interface tbls_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [tbls_pkg::POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

[src/tbls_probe.sv]
`default_nettype none

module tbls_probe (
    input  wire tbls_pkg::action_t                 mode,
    input  wire tbls_pkg::bound_t                  lo,
    input  wire tbls_pkg::bound_t                  hi,
    input  wire logic [tbls_pkg::IDX_W-1:0]        addr,
    input  wire logic [tbls_pkg::VALUE_WIDTH-1:0]  entry,
    input  wire logic [tbls_pkg::VALUE_WIDTH-1:0]  key,
    output tbls_pkg::probe_t                       pr
);

    tbls_pkg::bound_t mid;
    tbls_pkg::bound_t lo_n;
    tbls_pkg::bound_t hi_n;
    logic             greater;

    always_comb
    begin
        mid     = tbls_pkg::bound_t'(addr);
        greater = $signed(entry) > $signed(key);
        lo_n    = lo;
        hi_n    = hi;
        if (mode == tbls_pkg::ACT_BSEARCH)
        begin
            if (greater)
                hi_n = mid - tbls_pkg::bound_t'(1);
            else
                lo_n = mid + tbls_pkg::bound_t'(1);
        end
        else
        begin
            lo_n = lo + tbls_pkg::bound_t'(1);
        end

        pr.hit       = (entry == key);
        pr.empty     = (hi_n < lo_n);
        pr.lo_next   = lo_n;
        pr.hi_next   = hi_n;
        pr.addr_next = tbls_pkg::probe_addr(mode, lo_n, hi_n);
    end

endmodule

`default_nettype wire

[src/table_binary_linear_search.sv]
// Write beat: stored at the edge it is accepted; ready stays high.
// Search beat: one table probe per cycle (one read of the table RAM each), N probes;
// the DONE state then registers the result once the output register is free.
// Binary mode: N <= log2(depth)+1 (11 at 1024); linear mode: N <= range length.
// A new beat is accepted once the result sits in the output register.
// Reset clears control and output valid; table contents stay undefined until written.
`default_nettype none

module table_binary_linear_search (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbls_req_if.sink    req,
    tbls_rsp_if.source  rsp
);

    logic [tbls_pkg::VALUE_WIDTH-1:0] mem [tbls_pkg::TABLE_DEPTH];

    tbls_pkg::state_t  state_reg, state_next;
    tbls_pkg::action_t mode_reg;
    tbls_pkg::action_t act;
    tbls_pkg::bound_t  lo_reg, hi_reg, lo_in, hi_in;
    tbls_pkg::probe_t  pr;

    logic [tbls_pkg::VALUE_WIDTH-1:0] key_reg;
    logic [tbls_pkg::VALUE_WIDTH-1:0] rd_data_reg;
    logic [tbls_pkg::IDX_W-1:0]       addr_reg;
    logic [tbls_pkg::IDX_W-1:0]       rd_addr;
    logic                             hit_reg;
    logic                             out_valid_reg;
    logic                             found_reg;
    logic [tbls_pkg::POS_W-1:0]       pos_reg;
    logic                             accept;
    logic                             is_search;
    logic                             wr_en;
    logic                             out_free;

    assign act       = tbls_pkg::action_t'(req.action);
    assign accept    = req.valid && req.ready;
    assign is_search = (act == tbls_pkg::ACT_BSEARCH) || (act == tbls_pkg::ACT_LSEARCH);
    assign wr_en     = accept && (act == tbls_pkg::ACT_WRITE)
                       && (32'(req.entry_index) < tbls_pkg::TABLE_DEPTH);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign lo_in     = tbls_pkg::bound_t'(req.range_low);

    always_comb
    begin
        if (32'(req.range_high) > tbls_pkg::TABLE_DEPTH - 1)
            hi_in = tbls_pkg::bound_t'(tbls_pkg::TABLE_DEPTH - 1);
        else
            hi_in = tbls_pkg::bound_t'(req.range_high);
    end

    tbls_probe u_probe (
        .mode  (mode_reg),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .addr  (addr_reg),
        .entry (rd_data_reg),
        .key   (key_reg),
        .pr    (pr)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbls_pkg::S_IDLE:
            begin
                if (req.valid && is_search)
                    state_next = (hi_in < lo_in) ? tbls_pkg::S_DONE : tbls_pkg::S_EVAL;
            end
            tbls_pkg::S_EVAL:
            begin
                if (pr.hit || pr.empty)
                    state_next = tbls_pkg::S_DONE;
            end
            tbls_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = tbls_pkg::S_IDLE;
            end
            default: state_next = tbls_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready    = (state_reg == tbls_pkg::S_IDLE);
        rsp.valid    = out_valid_reg;
        rsp.found    = found_reg;
        rsp.position = pos_reg;
        if (state_reg == tbls_pkg::S_IDLE)
            rd_addr = tbls_pkg::probe_addr(act, lo_in, hi_in);
        else
            rd_addr = pr.addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbls_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tbls_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_search)
        begin
            mode_reg <= act;
            key_reg  <= req.search_key[tbls_pkg::VALUE_WIDTH-1:0];
            lo_reg   <= lo_in;
            hi_reg   <= hi_in;
            addr_reg <= rd_addr;
            hit_reg  <= 1'b0;
        end
        else if (state_reg == tbls_pkg::S_EVAL)
        begin
            lo_reg  <= pr.lo_next;
            hi_reg  <= pr.hi_next;
            hit_reg <= pr.hit;
            // keep the matching address as the position
            if (!pr.hit)
                addr_reg <= pr.addr_next;
        end

        if (state_reg == tbls_pkg::S_DONE && out_free)
        begin
            found_reg <= hit_reg;
            pos_reg   <= hit_reg ? tbls_pkg::POS_W'(addr_reg) : '0;
        end
    end

    // table RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[req.entry_index[tbls_pkg::IDX_W-1:0]] <=
                req.entry_value[tbls_pkg::VALUE_WIDTH-1:0];
        rd_data_reg <= mem[rd_addr];
    end

    a_probe_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tbls_pkg::S_EVAL |-> lo_reg <= hi_reg)
        else $error("probing an empty range");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tbls_pkg::S_EVAL |->
            tbls_pkg::bound_t'(addr_reg) >= lo_reg && tbls_pkg::bound_t'(addr_reg) <= hi_reg)
        else $error("probe address outside range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tbls_pkg::S_DONE))
        else $error("result raised outside done state");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> pos_reg == '0)
        else $error("miss carries non-zero position");

endmodule

`default_nettype wire
